// ===== rtl/trt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trt_pkg: shared types and constants of the timestamp lru record table
// Word formats, status codes, register indexes and table sizing.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W        = 6;
  localparam int STATUS_W      = 3;

  localparam logic [31:0] STAMP_LIMIT = 32'h7fff_ffff;

  // opcodes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // register indexes
  localparam logic REG_LOCK    = 1'b0;
  localparam logic REG_INVALID = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd6;

  typedef struct packed {
    logic        opcode;
    logic [31:0] object_id;
    logic [31:0] frame_count;
  } item_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [31:0]         evicted_id;
  } result_word_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/trt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trt_cell: one table entry of the rotating chain
// Holds an id and a timestamp and takes its neighbour's entry on each shift.
// ----------------------------------------------------------------------------
module trt_cell (
  input  wire             clk,
  input  wire             rst,
  input  wire             shift_en,
  input  trt_pkg::entry_t entry_in,
  output trt_pkg::entry_t entry_out
);
  import trt_pkg::*;

  entry_t entry;

  // a zero stamp marks the entry empty, so reset clears the table
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift_en) begin
      entry <= entry_in;
    end
  end

  assign entry_out = entry;

endmodule
`default_nettype wire

// ===== rtl/trt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trt_ctrl: sequencer of the record table
// Rotates the table past the head cell, matches, picks the oldest entry,
// writes on the wrap path and registers the result word.
// ----------------------------------------------------------------------------
module trt_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_stall,
  input  trt_pkg::item_word_t   item,
  output logic                  result_valid,
  input  wire                   result_stall,
  output trt_pkg::result_word_t result,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_index,
  input  wire  [31:0]           cfg_data,
  output logic                  shift_en,
  input  trt_pkg::entry_t       head,
  output trt_pkg::entry_t       tail
);
  import trt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]       state;
  logic [IDX_W-1:0] pos;
  logic             op;
  logic [31:0]      key;
  logic [31:0]      frame;
  logic             matched;
  logic [31:0]      lowest;
  logic [IDX_W-1:0] best;
  logic [31:0]      evict;
  result_word_t     res;
  logic             playback_lock;
  logic [31:0]      invalid_id;

  logic             last;
  logic             hit;
  logic             res_load;

  assign last       = (pos == IDX_W'(TABLE_ENTRIES - 1));
  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign shift_en   = (state == S_SCAN) || (state == S_FILL);
  assign res_load   = (state == S_DONE) && (!result_valid || !result_stall);

  // a record matches live entries only, a delete matches any entry
  assign hit = (state == S_SCAN) && !matched && (head.id == key) &&
               ((op == OP_DELETE) || (head.stamp != 32'd0));

  always_comb begin
    tail = head;
    if (hit) begin
      tail.stamp = (op == OP_DELETE) ? 32'd0 : frame;
    end else if ((state == S_FILL) && (pos == best)) begin
      tail.id    = key;
      tail.stamp = frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playback_lock <= 1'b0;
      invalid_id    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOCK:    playback_lock <= cfg_data[0];
        REG_INVALID: invalid_id    <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op      <= item.opcode;
            key     <= item.object_id;
            frame   <= item.frame_count;
            pos     <= '0;
            matched <= 1'b0;
            lowest  <= STAMP_LIMIT;
            best    <= '0;
            evict   <= '0;
            if (playback_lock || (item.object_id == invalid_id)) begin
              res   <= '{status: ST_IGNORED, slot: '0, evicted_id: '0};
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pos <= last ? '0 : pos + 1'b1;
          if (hit) begin
            matched <= 1'b1;
            res     <= '{status: (op == OP_DELETE) ? ST_DELETED : ST_REFRESHED,
                         slot: SLOT_W'(pos), evicted_id: '0};
          end else if (!matched && (head.stamp < lowest)) begin
            // once an empty entry is seen nothing can be lower
            lowest <= head.stamp;
            best   <= pos;
            evict  <= head.id;
          end
          if (last) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (matched) begin
            state <= S_DONE;
          end else if (op == OP_DELETE) begin
            res   <= '{status: ST_NOT_FOUND, slot: '0, evicted_id: '0};
            state <= S_DONE;
          end else if (lowest == STAMP_LIMIT) begin
            res   <= '{status: ST_DROPPED, slot: '0, evicted_id: '0};
            state <= S_DONE;
          end else begin
            if (lowest == 32'd0) begin
              res <= '{status: ST_FILLED, slot: SLOT_W'(best), evicted_id: '0};
            end else begin
              res <= '{status: ST_REPLACED, slot: SLOT_W'(best), evicted_id: evict};
            end
            state <= S_FILL;
          end
        end
        S_FILL: begin
          pos <= last ? '0 : pos + 1'b1;
          if (last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register lets a new item start while the last word waits
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/timestamp_lru_record_table_top.sv =====
`default_nettype none
// An ignored item goes to the result register without a pass over the table.
// A refresh, delete, miss or drop takes one pass over the table.
// An insert takes two passes, one to search and one to write.
// One item at a time; the block stays busy longer while the result stalls.
// Reset (synchronous) empties every entry and clears both registers.
// ----------------------------------------------------------------------------
// timestamp_lru_record_table_top: id and timestamp table with lru replacement
// A ring of entry cells rotated by the sequencer; matching and writes happen
// at the head of the ring.
// ----------------------------------------------------------------------------
module timestamp_lru_record_table_top (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_stall,
  input  trt_pkg::item_word_t   item,
  output logic                  result_valid,
  input  wire                   result_stall,
  output trt_pkg::result_word_t result,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_index,
  input  wire  [31:0]           cfg_data
);
  import trt_pkg::*;

  entry_t ring [TABLE_ENTRIES];
  entry_t tail;
  logic   shift_en;

  genvar k;
  generate
    for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      if (k == TABLE_ENTRIES - 1) begin : g_last
        trt_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift_en  (shift_en),
          .entry_in  (tail),
          .entry_out (ring[k])
        );
      end else begin : g_mid
        trt_cell u_cell (
          .clk       (clk),
          .rst       (rst),
          .shift_en  (shift_en),
          .entry_in  (ring[k+1]),
          .entry_out (ring[k])
        );
      end
    end
  endgenerate

  trt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .shift_en     (shift_en),
    .head         (ring[0]),
    .tail         (tail)
  );

  // no item may enter while the table is rotating
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    shift_en |-> item_stall)
    else $error("item accepted during table rotation");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("block not busy after accepting an item");

  // only a replacement reports an evicted id
  a_evict_only_replace: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_REPLACED)) |-> (result.evicted_id == 32'd0))
    else $error("evicted id on a non-replacement word");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status <= ST_IGNORED))
    else $error("undefined status code");

endmodule
`default_nettype wire
